// ===== hw/rtl/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 package
// Shared types, constants and round functions for the SM4 block encryptor.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int NumRounds = 32;
  localparam int RoundIdxW = $clog2(NumRounds);
  localparam int CfgIdxW   = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1
  } sm4_reg_e;

  // Key expansion sequencer states.
  typedef enum logic {
    KxIdle = 1'b0,
    KxRun  = 1'b1
  } kx_state_e;

  // Four-word cipher state, w0 is the oldest word of the window.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } sm4_state_t;

  // Expanded round keys, entry 0 is used by the first round.
  typedef logic [0:NumRounds-1][31:0] sm4_rk_t;

  // System parameter FK, words FK0..FK3 from most to least significant.
  localparam logic [127:0] FamilyKey = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  localparam logic [7:0] SBox [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Apply the S-box to each byte of a word.
  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = SBox[w[8*k +: 8]];
    end
    return r;
  endfunction

  // Linear transform of the data rounds.
  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Linear transform of the key schedule.
  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // Chain constant CK: byte j of word i is (4*i+j)*7 modulo 256.
  function automatic logic [31:0] chain_const(input logic [RoundIdxW-1:0] i);
    logic [31:0] r;
    logic [7:0]  t;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      t = {1'b0, i, 2'(j)};
      r[8*(3-j) +: 8] = 8'({t, 3'b000} - {3'b000, t});
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sm4_block_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// SM4 block encryptor
// Encrypts one 128-bit block per word with a 32-stage round pipeline.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   plain_high_i, plain_low_i
//   out       output     out_valid_o / out_ready_i cipher_high_o, cipher_low_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word enters per cycle while the round keys are ready and the output is
// not stalled; it passes one round per pipeline stage, the last stage being the output.
// After reset and after every key write the key schedule runs one round per
// cycle until all round keys are expanded, and in_ready_o stays low until it is done.
// A stalled output holds its word; empty stages upstream keep filling.
//
module sm4_block_encrypt_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [63:0]                 plain_high_i,
  input  logic [63:0]                 plain_low_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 cipher_high_o,
  output logic [63:0]                 cipher_low_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sm4_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);

  logic                                   keys_ready;
  sm4_pkg::sm4_rk_t                       rk;
  logic                [sm4_pkg::NumRounds:0] stage_valid;
  logic                [sm4_pkg::NumRounds:0] stage_ready;
  sm4_pkg::sm4_state_t                    stage_x [sm4_pkg::NumRounds+1];

  // Key registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Key schedule and round key store.
  sm4_key_exp u_key_exp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .keys_ready_o (keys_ready),
    .rk_o         (rk)
  );

  // Pipeline entry, held off while round keys are being expanded.
  assign stage_valid[0] = in_valid_i && keys_ready;
  assign in_ready_o     = stage_ready[0] && keys_ready;
  assign stage_x[0]     = {plain_high_i, plain_low_i};

  // One round per stage.
  for (genvar r = 0; r < sm4_pkg::NumRounds; r++) begin : g_round
    sm4_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[r]),
      .ready_o (stage_ready[r]),
      .x_i     (stage_x[r]),
      .rk_i    (rk[r]),
      .valid_o (stage_valid[r+1]),
      .ready_i (stage_ready[r+1]),
      .x_o     (stage_x[r+1])
    );
  end

  // Last stage is the output register; the four state words leave in reversed order.
  assign stage_ready[sm4_pkg::NumRounds] = out_ready_i;
  assign out_valid_o   = stage_valid[sm4_pkg::NumRounds];
  assign cipher_high_o = {stage_x[sm4_pkg::NumRounds].w3, stage_x[sm4_pkg::NumRounds].w2};
  assign cipher_low_o  = {stage_x[sm4_pkg::NumRounds].w1, stage_x[sm4_pkg::NumRounds].w0};

endmodule

// ===== hw/rtl/sm4_round.sv =====
// ----------------------------------------------------------------------------
// SM4 round stage
// One cipher round followed by a register stage with valid/ready handshake.
// ----------------------------------------------------------------------------
module sm4_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sm4_pkg::sm4_state_t x_i,
  input  logic [31:0]         rk_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sm4_pkg::sm4_state_t x_o
);

  logic                valid_q;
  sm4_pkg::sm4_state_t x_d, x_q;
  logic [31:0]         mix;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // Round function: the window slides by one word.
  always_comb begin
    mix    = sm4_pkg::sbox_word(x_i.w1 ^ x_i.w2 ^ x_i.w3 ^ rk_i);
    x_d.w0 = x_i.w1;
    x_d.w1 = x_i.w2;
    x_d.w2 = x_i.w3;
    x_d.w3 = x_i.w0 ^ sm4_pkg::lin_data(mix);
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Data register of the stage.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;

endmodule

// ===== hw/rtl/sm4_key_exp.sv =====
// ----------------------------------------------------------------------------
// SM4 key expansion
// Holds the key registers and expands them into 32 round keys, one per cycle, restarting on a key write.
// ----------------------------------------------------------------------------
module sm4_key_exp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [sm4_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  output logic                               keys_ready_o,
  output sm4_pkg::sm4_rk_t                   rk_o
);

  sm4_pkg::kx_state_e                state_d, state_q;
  logic [sm4_pkg::RoundIdxW-1:0]     cnt_d, cnt_q;
  logic [63:0]                       key_hi_d, key_hi_q;
  logic [63:0]                       key_lo_d, key_lo_q;
  logic [0:3][31:0]                  k_d, k_q;
  sm4_pkg::sm4_rk_t                  rk_q;
  logic                              key_wr;
  logic                              run_en;
  logic [31:0]                       new_key;

  // Key register writes; an unknown index is ignored.
  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    key_wr   = 1'b0;
    unique case (sm4_pkg::sm4_reg_e'(cfg_index_i))
      sm4_pkg::RegKeyHigh: begin
        if (cfg_valid_i) begin
          key_hi_d = cfg_data_i;
          key_wr   = 1'b1;
        end
      end
      sm4_pkg::RegKeyLow: begin
        if (cfg_valid_i) begin
          key_lo_d = cfg_data_i;
          key_wr   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state of the expansion sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sm4_pkg::KxIdle: begin
        if (key_wr) begin
          state_d = sm4_pkg::KxRun;
        end
      end
      sm4_pkg::KxRun: begin
        if (key_wr) begin
          state_d = sm4_pkg::KxRun;
        end else if (cnt_q == sm4_pkg::RoundIdxW'(sm4_pkg::NumRounds - 1)) begin
          state_d = sm4_pkg::KxIdle;
        end
      end
      default: state_d = sm4_pkg::KxIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    run_en       = (state_q == sm4_pkg::KxRun);
    keys_ready_o = (state_q == sm4_pkg::KxIdle);
  end

  // One key schedule round on the current window.
  always_comb begin
    new_key = k_q[0] ^ sm4_pkg::lin_key(sm4_pkg::sbox_word(
                k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4_pkg::chain_const(cnt_q)));
    if (key_wr) begin
      k_d   = {key_hi_d, key_lo_d} ^ sm4_pkg::FamilyKey;
      cnt_d = '0;
    end else if (run_en) begin
      k_d   = {k_q[1], k_q[2], k_q[3], new_key};
      cnt_d = cnt_q + 1'b1;
    end else begin
      k_d   = k_q;
      cnt_d = cnt_q;
    end
  end

  // Control and key registers; reset starts an expansion of the zero key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sm4_pkg::KxRun;
      cnt_q    <= '0;
      key_hi_q <= '0;
      key_lo_q <= '0;
      k_q      <= sm4_pkg::FamilyKey;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      k_q      <= k_d;
    end
  end

  // Round key store, written in order during an expansion.
  always_ff @(posedge clk_i) begin
    if (run_en && !key_wr) begin
      rk_q[cnt_q] <= new_key;
    end
  end

  assign rk_o = rk_q;

  // The counter rests at zero between expansions.
  a_idle_cnt_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sm4_pkg::KxIdle |-> cnt_q == '0)
    else $error("key expansion counter not at zero while idle");

  // A key write always starts a fresh expansion.
  a_write_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> state_q == sm4_pkg::KxRun && cnt_q == '0)
    else $error("key write did not restart expansion");

  // After the last round without a new write the keys are ready.
  a_last_round : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_en && !key_wr && cnt_q == sm4_pkg::RoundIdxW'(sm4_pkg::NumRounds - 1)
    |=> keys_ready_o)
    else $error("key expansion did not finish after the last round");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// SM4 block encryptor testbench
// Runs a short table of directed blocks and key writes, then random blocks
// under random keys, with idle cycles on the input and the output side. Each
// result word is compared with a local SM4 cipher model or with a known
// answer typed into the table.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [63:0] AllOnes       = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] StdHigh       = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] StdLow        = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] StdCipherHigh = 64'h681e_df34_d206_965e;
  localparam logic [63:0] StdCipherLow  = 64'h86b3_e94f_536e_4246;

  // Register indexes that map to no register.
  localparam logic [sm4_pkg::CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [sm4_pkg::CfgIdxW-1:0] RegSpare3 = 2'd3;

  localparam int SettleCycles = 40;
  localparam int SegmentBlocks = 75;

  // SM4 substitution table.
  localparam logic [7:0] SubTab [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_pair_t;

  typedef enum logic [0:0] {
    RowBlock = 1'b0,
    RowKey   = 1'b1
  } row_kind_e;

  // One row of the directed table: a block to encrypt or a key register write.
  typedef struct packed {
    row_kind_e                    kind;
    logic [sm4_pkg::CfgIdxW-1:0]  idx;
    logic [63:0]                  a;
    logic [63:0]                  b;
    logic                         known;
    logic [63:0]                  want_hi;
    logic [63:0]                  want_lo;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, AllOnes, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h0, AllOnes, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
      1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
      1'b0, 64'h0, 64'h0},
    '{RowKey, sm4_pkg::RegKeyHigh, StdHigh, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowKey, sm4_pkg::RegKeyLow, StdLow, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, StdHigh, StdLow, 1'b1, StdCipherHigh,
      StdCipherLow},
    '{RowBlock, sm4_pkg::RegKeyHigh, StdHigh, StdLow, 1'b1, StdCipherHigh,
      StdCipherLow},
    // Writes to unused indexes must leave the round keys alone.
    '{RowKey, RegSpare2, AllOnes, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, StdHigh, StdLow, 1'b1, StdCipherHigh,
      StdCipherLow},
    '{RowKey, RegSpare3, AllOnes, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, StdHigh, StdLow, 1'b1, StdCipherHigh,
      StdCipherLow},
    '{RowKey, sm4_pkg::RegKeyHigh, AllOnes, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowKey, sm4_pkg::RegKeyLow, AllOnes, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, StdHigh, StdLow, 1'b0, 64'h0, 64'h0},
    '{RowKey, sm4_pkg::RegKeyHigh, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowKey, sm4_pkg::RegKeyLow, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{RowBlock, sm4_pkg::RegKeyHigh, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0}
  };

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_ready_o;
  logic [63:0]                 plain_high    = '0;
  logic [63:0]                 plain_low     = '0;
  logic                        out_valid_o;
  logic                        out_ready     = 1'b0;
  logic [63:0]                 cipher_high_o;
  logic [63:0]                 cipher_low_o;
  logic                        cfg_valid     = 1'b0;
  logic                        cfg_ready_o;
  logic [sm4_pkg::CfgIdxW-1:0] cfg_index     = sm4_pkg::RegKeyHigh;
  logic [63:0]                 cfg_data      = '0;

  // Known answer that travels with the block on the input, if any.
  logic               known_q       = 1'b0;
  logic [63:0]        known_hi_q    = '0;
  logic [63:0]        known_lo_q    = '0;

  // Model state: key registers and the expanded round keys.
  logic [63:0]        model_key_hi  = '0;
  logic [63:0]        model_key_lo  = '0;
  logic [31:0]        round_keys [sm4_pkg::NumRounds];

  cipher_pair_t       pending_cipher [$];
  int                 fail_count    = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  sm4_block_encrypt_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .plain_high_i  (plain_high),
    .plain_low_i   (plain_low),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .cipher_high_o (cipher_high_o),
    .cipher_low_o  (cipher_low_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_bytes(input logic [31:0] w);
    return {SubTab[w[31:24]], SubTab[w[23:16]], SubTab[w[15:8]], SubTab[w[7:0]]};
  endfunction

  // Key schedule: fill round_keys from the 128-bit key.
  function automatic void expand_round_keys(input logic [63:0] kh, input logic [63:0] kl);
    logic [31:0] k [4];
    logic [31:0] ck;
    logic [31:0] t;
    logic [7:0]  cb;
    k[0] = kh[63:32] ^ 32'ha3b1bac6;
    k[1] = kh[31:0]  ^ 32'h56aa3350;
    k[2] = kl[63:32] ^ 32'h677d9197;
    k[3] = kl[31:0]  ^ 32'hb27022dc;
    for (int i = 0; i < sm4_pkg::NumRounds; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) begin
        cb = 8'((4 * i + j) * 7);
        ck = {ck[23:0], cb};
      end
      t = sub_bytes(k[1] ^ k[2] ^ k[3] ^ ck);
      t = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
      round_keys[i] = t;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = t;
    end
  endfunction

  // Encrypt one block with the current round keys.
  function automatic cipher_pair_t encrypt_block(input logic [63:0] ph, input logic [63:0] pl);
    logic [31:0]  x [4];
    logic [31:0]  t;
    cipher_pair_t r;
    x[0] = ph[63:32];
    x[1] = ph[31:0];
    x[2] = pl[63:32];
    x[3] = pl[31:0];
    for (int i = 0; i < sm4_pkg::NumRounds; i++) begin
      t = sub_bytes(x[1] ^ x[2] ^ x[3] ^ round_keys[i]);
      t = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    r.hi = {x[3], x[2]};
    r.lo = {x[1], x[0]};
    return r;
  endfunction

  // Receiver: drop ready at random.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track key writes and accepted blocks, and check every result word.
  always @(posedge clk_i) begin : monitor
    cipher_pair_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          sm4_pkg::RegKeyHigh: model_key_hi = cfg_data;
          sm4_pkg::RegKeyLow:  model_key_lo = cfg_data;
          default: ;
        endcase
        expand_round_keys(model_key_hi, model_key_lo);
      end
      if (in_valid && in_ready_o) begin
        if (known_q) begin
          want.hi = known_hi_q;
          want.lo = known_lo_q;
        end else begin
          want = encrypt_block(plain_high, plain_low);
        end
        pending_cipher.push_back(want);
      end
      if (out_valid_o && out_ready) begin
        if (pending_cipher.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h %h", $time,
                   cipher_high_o, cipher_low_o);
          fail_count++;
        end else begin
          want = pending_cipher.pop_front();
          if (cipher_high_o !== want.hi) begin
            $display("%0t: cipher_high expected %h, got %h", $time, want.hi,
                     cipher_high_o);
            fail_count++;
          end
          if (cipher_low_o !== want.lo) begin
            $display("%0t: cipher_low expected %h, got %h", $time, want.lo,
                     cipher_low_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Offer one block, with an optional known answer, and wait until it is taken.
  task automatic send_block(input logic [63:0] ph, input logic [63:0] pl,
                            input logic known, input logic [63:0] khi,
                            input logic [63:0] klo);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    plain_high <= ph;
    plain_low  <= pl;
    known_q    <= known;
    known_hi_q <= khi;
    known_lo_q <= klo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending, let every result come out, then give the pipeline time to empty.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cipher.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one key register and then leave the channel idle.
  task automatic write_key_reg(input logic [sm4_pkg::CfgIdxW-1:0] idx,
                               input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random 64-bit value, biased toward the extremes now and then.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Main stimulus.
  initial begin
    stim_row_t row;
    int        recv_modes [3];
    int        send_modes [3];
    send_modes = '{31, 74, 0};
    recv_modes = '{74, 31, 0};
    expand_round_keys(model_key_hi, model_key_lo);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      if (row.kind == RowKey) begin
        drain_and_settle();
        write_key_reg(row.idx, row.a);
      end else begin
        send_block(row.a, row.b, row.known, row.want_hi, row.want_lo);
      end
    end

    // Random blocks under random keys, in three idling modes.
    for (int m = 0; m < 3; m++) begin
      for (int s = 0; s < 3; s++) begin
        drain_and_settle();
        send_idle_pct = send_modes[m];
        recv_idle_pct = recv_modes[m];
        if ($urandom_range(3) != 0) write_key_reg(sm4_pkg::RegKeyHigh, rand_word());
        if ($urandom_range(3) == 0) write_key_reg(RegSpare2, rand_word());
        if ($urandom_range(3) != 0) write_key_reg(sm4_pkg::RegKeyLow, rand_word());
        if ($urandom_range(3) == 0) write_key_reg(RegSpare3, rand_word());
        for (int i = 0; i < SegmentBlocks; i++) begin
          send_block(rand_word(), rand_word(), 1'b0, '0, '0);
        end
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_round.sv
hw/rtl/sm4_key_exp.sv
hw/rtl/sm4_block_encrypt_top.sv
test/testbench.sv
